>>> hdl/block_receipt_bitmap_tracker_unit_macros.svh
// Assertion macros for the received-block bitmap tracker.
// Included by the top level; the assertions drop out when SYNTH is defined.
`ifndef BLOCK_RECEIPT_BITMAP_TRACKER_UNIT_MACROS_SVH
`define BLOCK_RECEIPT_BITMAP_TRACKER_UNIT_MACROS_SVH

`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define BRBT_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("brbt same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define BRBT_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("brbt next-cycle check failed");
`else
`define BRBT_ASSERT_SAME(lbl, ante, cons)
`define BRBT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> hdl/brbt_pkg.sv
// Package for the received-block bitmap tracker: word types, codes and states.
// Used by the top level; no dependencies of its own.
`timescale 1ns / 1ps

package brbt_pkg;

  localparam int BITMAP_BYTES_DEF = 64;

  localparam int CFG_DATA_W = 16;

  // Register indexes of the configuration port.
  localparam logic CFG_BLOCK_BYTES  = 1'b0;
  localparam logic CFG_IMAGE_LENGTH = 1'b1;

  localparam logic [10:0] BLOCK_BYTES_RST  = 11'd64;
  localparam logic [15:0] IMAGE_LENGTH_RST = 16'd0;

  // Opcodes, echoed as result kinds.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_LIST  = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  // Store status of a mark.
  localparam logic [1:0] STORE_NEW   = 2'd0;
  localparam logic [1:0] STORE_DUP   = 2'd1;
  localparam logic [1:0] STORE_RANGE = 2'd2;

  localparam logic [6:0] LIMIT_CAP  = 7'd64;
  localparam logic [9:0] PREFIX_MAX = 10'd1023;
  localparam logic [7:0] BYTE_FULL  = 8'hff;
  localparam logic [2:0] BIT_LAST   = 3'h7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [8:0] block_number;
    logic [6:0] id_limit;
  } cmd_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [1:0]  store_status;
    logic [15:0] block_offset;
    logic        id_valid;
    logic [8:0]  missing_id;
    logic [9:0]  received_prefix;
    logic        complete;
    logic        last;
  } rsp_word_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MARK,
    ST_SCAN_RD,
    ST_SCAN_LD,
    ST_SCAN_BIT,
    ST_FINISH
  } state_t;

endpackage

>>> hdl/brbt_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies; the read data holds while no read is issued.
`timescale 1ns / 1ps

module brbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> hdl/block_receipt_bitmap_tracker_unit.sv
// Top level of the received-block bitmap tracker: sequencer and result register.
// Depends on brbt_pkg, brbt_ram and block_receipt_bitmap_tracker_unit_macros.svh.
//
//   Channel   Signals                          Carries
//   cmd       cmd_valid, cmd_stall, cmd_word   one command word per item
//   rsp       rsp_valid, rsp_stall, rsp_word   one or more result words per item
//   cfg       cfg_wr_en, cfg_index, cfg_data   register writes, no read-back
//
// A mark's bitmap read goes out in the accepting cycle; ST_MARK then checks the
// bit, writes the byte back and loads the result once the result register is free.
// A clear writes one byte per cycle in ST_CLEAR and sends its word from ST_FINISH.
// List and check walk the bitmap: each byte is read in ST_SCAN_RD and tested in
// ST_SCAN_LD, a byte that is not full is examined bit by bit in ST_SCAN_BIT, and
// ST_FINISH sends the final word.
// After reset the bitmap is cleared before the first command word is taken. The
// result register lets a new command be accepted while the last result waits
// under rsp_stall; a stalled result holds the scan.
`timescale 1ns / 1ps

`include "block_receipt_bitmap_tracker_unit_macros.svh"

module block_receipt_bitmap_tracker_unit #(
  parameter int BITMAP_BYTES = brbt_pkg::BITMAP_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  brbt_pkg::cmd_word_t              cmd_word,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output brbt_pkg::rsp_word_t              rsp_word,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [brbt_pkg::CFG_DATA_W-1:0] cfg_data
);

  import brbt_pkg::*;

  // Geometry of the bitmap. One byte holds eight consecutive blocks.
  localparam int BITMAP_BITS = BITMAP_BYTES * 8;
  localparam int ADDR_W      = (BITMAP_BYTES > 1) ? $clog2(BITMAP_BYTES) : 1;
  localparam int IDX_W       = $clog2(BITMAP_BITS + 1);
  // The running offset i * block size; never narrower than the image length.
  localparam int ACC_W       = (IDX_W + 11 > 17) ? IDX_W + 11 : 17;

  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(BITMAP_BYTES - 1);
  localparam logic [IDX_W-1:0]  BITS_IDX  = IDX_W'(BITMAP_BITS);

  // Configuration registers.
  logic [10:0] block_bytes;
  logic [15:0] image_length;

  // Sequencer state.
  state_t            state, state_next;
  logic [ADDR_W-1:0] clr_addr, clr_addr_next;
  logic              clr_reply, clr_reply_next;
  logic [1:0]        op_q, op_next;
  logic [IDX_W-1:0]  idx, idx_next;
  logic [ACC_W-1:0]  acc, acc_next;
  logic [6:0]        cnt, cnt_next;
  logic [6:0]        lim, lim_next;
  logic              pend_valid, pend_valid_next;

  // Payload registers.
  logic [8:0]  bn_q, bn_next;
  logic [19:0] ofs_q, ofs_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic [8:0]  pend_id, pend_id_next;

  // Bitmap memory.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  logic [7:0]        ram_rdata;

  // Result register.
  logic      emit;
  rsp_word_t res;
  logic      rsp_free;

  // Derived values.
  logic [10:0]      bs_eff;
  logic [ACC_W-1:0] len_ext;
  logic             cur_bit;
  logic             acc_done;
  logic             out_of_range;

  brbt_ram #(
    .WIDTH (8),
    .DEPTH (BITMAP_BYTES)
  ) u_bitmap (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // A block size of zero behaves as one byte.
  assign bs_eff   = (block_bytes == 11'd0) ? 11'd1 : block_bytes;
  assign len_ext  = ACC_W'(image_length);
  assign cur_bit  = cur_byte[idx[2:0]];
  // The scan index has left the image once its byte offset reaches the length.
  assign acc_done = (acc >= len_ext);
  assign out_of_range = (ofs_q >= 20'(image_length)) ||
                        (32'(bn_q) >= 32'(BITMAP_BITS));

  assign cmd_stall = (state != ST_IDLE);
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Configuration writes. The port is only to be used while the block is idle; the block does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes  <= BLOCK_BYTES_RST;
      image_length <= IMAGE_LENGTH_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_BLOCK_BYTES:  block_bytes  <= cfg_data[10:0];
        CFG_IMAGE_LENGTH: image_length <= cfg_data[15:0];
        default:          block_bytes  <= block_bytes;
      endcase
    end
  end

  // Control registers. Reset starts the clearing sweep of the bitmap.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      clr_reply  <= 1'b0;
      op_q       <= OP_CLEAR;
      idx        <= '0;
      acc        <= '0;
      cnt        <= '0;
      lim        <= LIMIT_CAP;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      clr_addr   <= clr_addr_next;
      clr_reply  <= clr_reply_next;
      op_q       <= op_next;
      idx        <= idx_next;
      acc        <= acc_next;
      cnt        <= cnt_next;
      lim        <= lim_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    bn_q     <= bn_next;
    ofs_q    <= ofs_next;
    cur_byte <= cur_byte_next;
    pend_id  <= pend_id_next;
  end

  // The result register takes a new word whenever it is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (emit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      rsp_word <= res;
    end
  end

  // Sequencer. Missing ids are held back by one so that the final one can be
  // sent with last set once the scan knows that no further id follows.
  always_comb begin
    logic step;

    state_next      = state;
    clr_addr_next   = clr_addr;
    clr_reply_next  = clr_reply;
    op_next         = op_q;
    idx_next        = idx;
    acc_next        = acc;
    cnt_next        = cnt;
    lim_next        = lim;
    pend_valid_next = pend_valid;
    bn_next         = bn_q;
    ofs_next        = ofs_q;
    cur_byte_next   = cur_byte;
    pend_id_next    = pend_id;
    ram_we          = 1'b0;
    ram_waddr       = clr_addr;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = ADDR_W'(idx >> 3);
    emit            = 1'b0;
    res             = '0;
    step            = 1'b0;

    unique case (state)
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_addr == ADDR_LAST) begin
          clr_addr_next = '0;
          state_next    = clr_reply ? ST_FINISH : ST_IDLE;
        end else begin
          clr_addr_next = clr_addr + 1'b1;
        end
      end

      ST_IDLE: begin
        if (cmd_valid) begin
          op_next         = cmd_word.opcode;
          bn_next         = cmd_word.block_number;
          ofs_next        = 20'(cmd_word.block_number) * 20'(bs_eff);
          idx_next        = '0;
          acc_next        = '0;
          cnt_next        = '0;
          pend_valid_next = 1'b0;
          lim_next        = (cmd_word.id_limit == 7'd0 || cmd_word.id_limit > LIMIT_CAP) ?
                            LIMIT_CAP : cmd_word.id_limit;
          unique case (cmd_word.opcode)
            OP_CLEAR: begin
              clr_reply_next = 1'b1;
              state_next     = ST_CLEAR;
            end
            OP_MARK: begin
              ram_re     = 1'b1;
              ram_raddr  = ADDR_W'(cmd_word.block_number >> 3);
              state_next = ST_MARK;
            end
            default: begin
              state_next = ST_SCAN_RD;
            end
          endcase
        end
      end

      ST_MARK: begin
        if (rsp_free) begin
          emit             = 1'b1;
          res.result_kind  = OP_MARK;
          res.last         = 1'b1;
          state_next       = ST_IDLE;
          if (out_of_range) begin
            res.store_status = STORE_RANGE;
          end else if (ram_rdata[bn_q[2:0]]) begin
            res.store_status = STORE_DUP;
            res.block_offset = ofs_q[15:0];
          end else begin
            res.store_status = STORE_NEW;
            res.block_offset = ofs_q[15:0];
            ram_we           = 1'b1;
            ram_waddr        = ADDR_W'(bn_q >> 3);
            ram_wdata        = ram_rdata | (8'd1 << bn_q[2:0]);
          end
        end
      end

      ST_SCAN_RD: begin
        if (idx == BITS_IDX || (op_q == OP_LIST && (acc_done || cnt == lim))) begin
          state_next = ST_FINISH;
        end else begin
          ram_re     = 1'b1;
          state_next = ST_SCAN_LD;
        end
      end

      ST_SCAN_LD: begin
        // A fully received byte holds no missing block and extends the prefix.
        if (ram_rdata == BYTE_FULL) begin
          idx_next   = idx + IDX_W'(8);
          acc_next   = acc + ACC_W'({bs_eff, 3'b000});
          state_next = ST_SCAN_RD;
        end else begin
          cur_byte_next = ram_rdata;
          state_next    = ST_SCAN_BIT;
        end
      end

      ST_SCAN_BIT: begin
        if (op_q == OP_CHECK) begin
          if (!cur_bit) begin
            state_next = ST_FINISH;
          end else begin
            step = 1'b1;
          end
        end else if (acc_done || cnt == lim) begin
          state_next = ST_FINISH;
        end else if (cur_bit) begin
          step = 1'b1;
        end else if (!pend_valid) begin
          pend_valid_next = 1'b1;
          pend_id_next    = 9'(idx);
          cnt_next        = cnt + 1'b1;
          step            = 1'b1;
        end else if (rsp_free) begin
          emit            = 1'b1;
          res.result_kind = OP_LIST;
          res.id_valid    = 1'b1;
          res.missing_id  = pend_id;
          pend_id_next    = 9'(idx);
          cnt_next        = cnt + 1'b1;
          step            = 1'b1;
        end
        if (step) begin
          idx_next = idx + 1'b1;
          acc_next = acc + ACC_W'(bs_eff);
          if (idx[2:0] == BIT_LAST) begin
            state_next = ST_SCAN_RD;
          end
        end
      end

      ST_FINISH: begin
        if (rsp_free) begin
          emit           = 1'b1;
          res.last       = 1'b1;
          clr_reply_next = 1'b0;
          state_next     = ST_IDLE;
          case (op_q)
            OP_CLEAR: begin
              res.result_kind = OP_CLEAR;
            end
            OP_LIST: begin
              res.result_kind = OP_LIST;
              res.id_valid    = pend_valid;
              res.missing_id  = pend_valid ? pend_id : 9'd0;
              pend_valid_next = 1'b0;
            end
            default: begin
              // The prefix matches the expected count when it covers the
              // image (or fills the bitmap) and one block fewer does not.
              res.result_kind     = OP_CHECK;
              res.received_prefix = (32'(idx) > 32'(PREFIX_MAX)) ? PREFIX_MAX : 10'(idx);
              res.complete        = (idx == BITS_IDX || acc_done) &&
                                    (idx == '0 || (acc - ACC_W'(bs_eff)) < len_ext);
            end
          endcase
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // A mark always goes straight to its read-modify-write cycle.
  `BRBT_ASSERT_NEXT(a_mark_enters_rmw, cmd_valid && !cmd_stall && cmd_word.opcode == OP_MARK, state == ST_MARK)
  // Only the clearing sweep and a mark may write the bitmap.
  `BRBT_ASSERT_SAME(a_ram_write_owner, ram_we, state == ST_CLEAR || state == ST_MARK)
  // A bit is only examined inside the bitmap.
  `BRBT_ASSERT_SAME(a_scan_index_bound, state == ST_SCAN_BIT, idx < BITS_IDX)
  // A listing never collects more ids than its limit.
  `BRBT_ASSERT_SAME(a_list_count_bound, op_q == OP_LIST && state != ST_IDLE && state != ST_CLEAR, cnt <= lim)

endmodule

>>> tb/bitmap_receipt_checker.sv
// Checker for the received-block bitmap tracker: predicts every result word and compares.
// Depends on brbt_pkg for the word types, opcodes, store codes and register indexes.
`timescale 1ns / 1ps

module bitmap_receipt_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cmd_valid,
  input  logic                            cmd_stall,
  input  brbt_pkg::cmd_word_t             cmd_word,
  input  logic                            rsp_valid,
  input  logic                            rsp_stall,
  input  brbt_pkg::rsp_word_t             rsp_word,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [brbt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatch_count,
  output int                              words_pending
);

  import brbt_pkg::*;

  localparam int unsigned BLOCK_BITS = BITMAP_BYTES_DEF * 8;

  logic [BLOCK_BITS-1:0] got_blocks;
  logic [10:0]           cur_block_bytes;
  logic [15:0]           cur_image_length;
  rsp_word_t             expected_words[$];

  // Works out every result word that one command word causes, in order.
  task automatic predict_results(input cmd_word_t w);
    rsp_word_t   r;
    int unsigned size;
    int unsigned span;
    int unsigned ofs;
    int unsigned lim;
    int unsigned cnt;
    int unsigned run;
    int unsigned i;
    size = (cur_block_bytes == 11'd0) ? 1 : int'(cur_block_bytes);
    span = (int'(cur_image_length) + size - 1) / size;
    if (span > BLOCK_BITS) span = BLOCK_BITS;
    r = '0;
    r.result_kind = w.opcode;
    r.last = 1'b1;
    case (w.opcode)
      OP_CLEAR: begin
        got_blocks = '0;
        expected_words.push_back(r);
      end
      OP_MARK: begin
        ofs = int'(w.block_number) * size;
        if (ofs >= int'(cur_image_length) || int'(w.block_number) >= BLOCK_BITS) begin
          r.store_status = STORE_RANGE;
        end else begin
          r.block_offset = ofs[15:0];
          if (got_blocks[w.block_number]) begin
            r.store_status = STORE_DUP;
          end else begin
            got_blocks[w.block_number] = 1'b1;
            r.store_status = STORE_NEW;
          end
        end
        expected_words.push_back(r);
      end
      OP_LIST: begin
        lim = int'(w.id_limit);
        if (lim == 0 || lim > int'(LIMIT_CAP)) lim = int'(LIMIT_CAP);
        cnt = 0;
        // Each missing id is held back one step so the final one can carry last.
        for (i = 0; i < span && cnt < lim; i++) begin
          if (!got_blocks[i]) begin
            if (cnt != 0) expected_words.push_back(r);
            r = '0;
            r.result_kind = OP_LIST;
            r.id_valid = 1'b1;
            r.missing_id = i[8:0];
            cnt++;
          end
        end
        r.last = 1'b1;
        expected_words.push_back(r);
      end
      default: begin
        run = 0;
        while (run < BLOCK_BITS && got_blocks[run]) run++;
        r.complete = (run == span);
        r.received_prefix = (run > int'(PREFIX_MAX)) ? PREFIX_MAX : run[9:0];
        expected_words.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  task automatic compare_result(input rsp_word_t got);
    rsp_word_t want;
    if (expected_words.size() == 0) begin
      $error("unexpected result word: %h", got);
      mismatch_count++;
    end else begin
      want = expected_words.pop_front();
      check_field("result_kind", want.result_kind, got.result_kind);
      check_field("store_status", want.store_status, got.store_status);
      check_field("block_offset", want.block_offset, got.block_offset);
      check_field("id_valid", want.id_valid, got.id_valid);
      check_field("missing_id", want.missing_id, got.missing_id);
      check_field("received_prefix", want.received_prefix, got.received_prefix);
      check_field("complete", want.complete, got.complete);
      check_field("last", want.last, got.last);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      got_blocks = '0;
      cur_block_bytes = BLOCK_BYTES_RST;
      cur_image_length = IMAGE_LENGTH_RST;
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BLOCK_BYTES:  cur_block_bytes = cfg_data[10:0];
          default:          cur_image_length = cfg_data;
        endcase
      end
      if (cmd_valid && !cmd_stall) predict_results(cmd_word);
      if (rsp_valid && !rsp_stall) compare_result(rsp_word);
    end
    words_pending = expected_words.size();
  end

endmodule

>>> tb/testbench.sv
// Top of the bench for block_receipt_bitmap_tracker_unit: clock, reset, stimulus and verdict.
// Depends on brbt_pkg, the tracker RTL and bitmap_receipt_checker.
`timescale 1ns / 1ps

module testbench;
  import brbt_pkg::*;

  // Generous bound: a list word can wait out a scan of the whole bitmap plus
  // random receiver stalls, and a few list commands give 64 words each.
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 16;
  localparam int SPAN_CAP = BITMAP_BYTES_DEF * 8;

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_stall;
  cmd_word_t             cmd_word;
  logic                  rsp_valid;
  logic                  rsp_stall;
  rsp_word_t             rsp_word;
  logic                  cfg_wr_en;
  logic                  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatch_count;
  int words_pending;
  int cycle_count = 0;

  // Shared knobs between the sender and the receiver process.
  logic hold_ask;   // sender asks the receiver for one long hold-off
  logic hold_over;  // receiver marks that the hold-off has been done
  logic calm;       // no idling on either side

  // Block count of the configuration as last written, so the random part can aim marks at
  // blocks that are inside the image.
  int unsigned tb_span;

  block_receipt_bitmap_tracker_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_word  (cmd_word),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bitmap_receipt_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_stall      (cmd_stall),
    .cmd_word       (cmd_word),
    .rsp_valid      (rsp_valid),
    .rsp_stall      (rsp_stall),
    .rsp_word       (rsp_word),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .words_pending  (words_pending)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Hard stop in case the block hangs or loses result words.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver. It stalls at random with a chance of 28 in a hundred, not at all while calm is
  // set, and once holds off for a long stretch so the block backs up and has
  // to stall its command side while the sender keeps offering words.
  initial begin
    rsp_stall = 1'b0;
    hold_over = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask && !hold_over) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_over = 1'b1;
        rsp_stall <= 1'b0;
      end else if (calm) begin
        rsp_stall <= 1'b0;
      end else begin
        rsp_stall <= ($urandom_range(0, 99) < 28);
      end
    end
  end

  // Offers one command word, with a random gap in front of it unless calm is
  // set, and returns at the rising edge where the word is taken. The word is
  // held steady for as long as the block stalls it.
  task automatic send_cmd(input logic [1:0] op, input logic [8:0] bn, input logic [6:0] lim);
    cmd_word_t w;
    w.opcode = op;
    w.block_number = bn;
    w.id_limit = lim;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 28) begin
      cmd_valid <= 1'b0;
      @(negedge clk);
      while ($urandom_range(0, 99) < 28) @(negedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_word <= w;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
  endtask

  // Stops offering and waits until every predicted word has come back, then
  // lets the block wind down its scan.
  task automatic drain();
    @(negedge clk);
    cmd_valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Writes both registers and records the expected block count, saturated at
  // the bitmap size. A block size of zero counts as one.
  task automatic set_config(input int unsigned size, input int unsigned len,
                            input logic [4:0] upper);
    int unsigned eff;
    cfg_write(CFG_BLOCK_BYTES, {upper, size[10:0]});
    cfg_write(CFG_IMAGE_LENGTH, len[15:0]);
    eff = (size == 0) ? 1 : size;
    tb_span = (len + eff - 1) / eff;
    if (tb_span > SPAN_CAP) tb_span = SPAN_CAP;
  endtask

  // Picks a random setting. Most settings give an image of a few dozen blocks
  // so that random marks fill it and the completeness check can succeed;
  // the rest cover the extremes of both registers.
  task automatic pick_config();
    int unsigned size;
    int unsigned len;
    int unsigned sel;
    int unsigned junk;
    sel = $urandom_range(0, 5);
    case (sel)
      0: begin
        size = $urandom_range(1, 16);
        len = size * $urandom_range(1, 40) - $urandom_range(0, size - 1);
      end
      1: begin
        size = $urandom_range(17, 1024);
        len = size * $urandom_range(1, 40) - $urandom_range(0, size - 1);
      end
      2: begin
        size = 0;
        len = $urandom_range(1, 48);
      end
      3: begin
        size = ($urandom_range(0, 1) == 1) ? 2047 : 1024;
        len = 65535;
      end
      4: begin
        size = $urandom_range(1, 2047);
        len = $urandom_range(0, 65535);
      end
      default: begin
        size = $urandom_range(1, 8);
        len = ($urandom_range(0, 1) == 1) ? 65535 : 0;
      end
    endcase
    if (len > 65535) len = 65535;
    // Data bits above the block size register are sometimes set; they must
    // be dropped by the block.
    junk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : 0;
    set_config(size, len, junk[4:0]);
  endtask

  // A run of random commands. Marks dominate and mostly land inside the
  // image; the others are lists with random limits, checks and a few clears.
  task automatic random_run(input int count);
    int          k;
    int unsigned pick;
    int unsigned bn;
    int unsigned lim;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      bn = $urandom_range(0, 511);
      lim = $urandom_range(0, 127);
      if (pick < 55) begin
        if (tb_span != 0 && $urandom_range(0, 99) < 85) bn = $urandom_range(0, tb_span - 1);
        send_cmd(OP_MARK, bn[8:0], lim[6:0]);
      end else if (pick < 73) begin
        if ($urandom_range(0, 1) == 1) lim = $urandom_range(1, 6);
        send_cmd(OP_LIST, bn[8:0], lim[6:0]);
      end else if (pick < 93) begin
        send_cmd(OP_CHECK, bn[8:0], lim[6:0]);
      end else begin
        send_cmd(OP_CLEAR, bn[8:0], lim[6:0]);
      end
    end
  endtask

  initial begin
    int p;
    rst = 1'b1;
    cmd_valid = 1'b0;
    cmd_word = '0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_BLOCK_BYTES;
    cfg_data = '0;
    hold_ask = 1'b0;
    calm = 1'b0;
    tb_span = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // With the reset image length of zero nothing is in range: the check is
    // complete at once, the list finds nothing missing and any mark is
    // rejected as beyond the image.
    send_cmd(OP_CHECK, 9'($urandom), 7'($urandom));
    send_cmd(OP_LIST, 9'($urandom), 7'd5);
    send_cmd(OP_MARK, 9'd0, 7'($urandom));

    // Sixteen-byte blocks in a 100-byte image: seven blocks, the last one
    // partial. Covers new and duplicate marks, marks beyond the image, a list
    // limit of zero (taken as the cap), a small limit, and a full image.
    drain();
    set_config(16, 100, 5'd0);
    send_cmd(OP_MARK, 9'd0, 7'($urandom));
    send_cmd(OP_MARK, 9'd1, 7'($urandom));
    send_cmd(OP_MARK, 9'd2, 7'($urandom));
    send_cmd(OP_MARK, 9'd1, 7'($urandom));
    send_cmd(OP_MARK, 9'd6, 7'($urandom));
    send_cmd(OP_MARK, 9'd7, 7'($urandom));
    send_cmd(OP_MARK, 9'd511, 7'h7f);
    send_cmd(OP_LIST, 9'($urandom), 7'd0);
    send_cmd(OP_LIST, 9'($urandom), 7'd2);
    send_cmd(OP_CHECK, 9'($urandom), 7'($urandom));
    send_cmd(OP_MARK, 9'd3, 7'($urandom));
    send_cmd(OP_MARK, 9'd4, 7'($urandom));
    send_cmd(OP_MARK, 9'd5, 7'($urandom));
    send_cmd(OP_CHECK, 9'($urandom), 7'($urandom));
    send_cmd(OP_LIST, 9'($urandom), 7'd64);
    send_cmd(OP_CLEAR, 9'h1ff, 7'h7f);
    send_cmd(OP_CHECK, 9'($urandom), 7'($urandom));

    // A block size of zero acts as one byte, and the largest image then has
    // more blocks than the bitmap, so the expected count saturates. The list
    // returns a full batch of 64 missing ids.
    drain();
    set_config(0, 65535, 5'd0);
    send_cmd(OP_MARK, 9'd511, 7'($urandom));
    send_cmd(OP_MARK, 9'd0, 7'($urandom));
    send_cmd(OP_LIST, 9'($urandom), 7'd64);
    send_cmd(OP_CHECK, 9'($urandom), 7'($urandom));

    // Fill blocks zero to two of a three-byte image, then shrink the image:
    // the received prefix now exceeds the expected count and the check must
    // not report the image as complete.
    drain();
    set_config(1, 3, 5'd0);
    send_cmd(OP_MARK, 9'd1, 7'($urandom));
    send_cmd(OP_MARK, 9'd2, 7'($urandom));
    drain();
    set_config(1, 2, 5'd0);
    send_cmd(OP_CHECK, 9'($urandom), 7'($urandom));

    // Random part: a fresh setting for each run of commands. The sender waits
    // for every outstanding word before each setting. One run has the long
    // receiver hold-off and one runs with no idling at all.
    for (p = 0; p < 12; p++) begin
      drain();
      pick_config();
      if ($urandom_range(0, 1) == 1) send_cmd(OP_CLEAR, 9'($urandom), 7'($urandom));
      hold_ask = (p == 2);
      calm = (p == 5);
      random_run(32);
      calm = 1'b0;
    end

    drain();
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/brbt_pkg.sv
hdl/brbt_ram.sv
hdl/block_receipt_bitmap_tracker_unit.sv
tb/bitmap_receipt_checker.sv
tb/testbench.sv
